@@ hdl/bgr_pkg.sv @@
// ----------------------------------------------------------------------------
// bgr_pkg: shared types, constants and font tables
// Glyph descriptors and packed glyph bitmap ROM for the character generator.
// ----------------------------------------------------------------------------
package bgr_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam logic [7:0] FIRST_CODE = 8'h20;
    localparam logic [7:0] LAST_CODE  = 8'h7E;
    localparam int ROM_BYTES  = 176;
    localparam int NUM_GLYPHS = 95;
    localparam int MAX_PIX    = 18;

    // glyph descriptor: byte offset, width, height, advance, y offset
    typedef struct packed {
        logic [7:0]        off;
        logic [1:0]        w;
        logic [2:0]        h;
        logic [2:0]        adv;
        logic signed [3:0] yo;
    } t_glyph;

    // control handed from the glyph sequencer to the output stage
    typedef struct packed {
        logic       pix;
        logic       close;
        logic [2:0] adv;
    } t_seq_ev;

    function automatic logic [7:0] rom_byte(input logic [7:0] a);
        logic [7:0] b;
        case (a)
            8'd0: b = 8'h00; 8'd1: b = 8'hE8; 8'd2: b = 8'hB4; 8'd3: b = 8'hBE;
            8'd4: b = 8'hFA; 8'd5: b = 8'h79; 8'd6: b = 8'hE4; 8'd7: b = 8'h85;
            8'd8: b = 8'h42; 8'd9: b = 8'hDB; 8'd10: b = 8'hD6; 8'd11: b = 8'hC0;
            8'd12: b = 8'h6A; 8'd13: b = 8'h40; 8'd14: b = 8'h95; 8'd15: b = 8'h80;
            8'd16: b = 8'hAA; 8'd17: b = 8'h80; 8'd18: b = 8'h5D; 8'd19: b = 8'h00;
            8'd20: b = 8'h60; 8'd21: b = 8'hE0; 8'd22: b = 8'h80; 8'd23: b = 8'h25;
            8'd24: b = 8'h48; 8'd25: b = 8'h76; 8'd26: b = 8'hDC; 8'd27: b = 8'h75;
            8'd28: b = 8'h40; 8'd29: b = 8'hC5; 8'd30: b = 8'h4E; 8'd31: b = 8'hC5;
            8'd32: b = 8'h1C; 8'd33: b = 8'hB7; 8'd34: b = 8'h92; 8'd35: b = 8'hF3;
            8'd36: b = 8'h1C; 8'd37: b = 8'h73; 8'd38: b = 8'hDE; 8'd39: b = 8'hE5;
            8'd40: b = 8'h48; 8'd41: b = 8'hF7; 8'd42: b = 8'hDE; 8'd43: b = 8'hF7;
            8'd44: b = 8'h9C; 8'd45: b = 8'hA0; 8'd46: b = 8'h46; 8'd47: b = 8'h2A;
            8'd48: b = 8'h22; 8'd49: b = 8'hE3; 8'd50: b = 8'h80; 8'd51: b = 8'h88;
            8'd52: b = 8'hA8; 8'd53: b = 8'hE5; 8'd54: b = 8'h04; 8'd55: b = 8'h57;
            8'd56: b = 8'hC6; 8'd57: b = 8'h57; 8'd58: b = 8'hDA; 8'd59: b = 8'hD7;
            8'd60: b = 8'h5C; 8'd61: b = 8'h72; 8'd62: b = 8'h46; 8'd63: b = 8'hD6;
            8'd64: b = 8'hDC; 8'd65: b = 8'hF3; 8'd66: b = 8'hCE; 8'd67: b = 8'hF3;
            8'd68: b = 8'hC8; 8'd69: b = 8'h73; 8'd70: b = 8'hD6; 8'd71: b = 8'hB7;
            8'd72: b = 8'hDA; 8'd73: b = 8'hE9; 8'd74: b = 8'h2E; 8'd75: b = 8'h24;
            8'd76: b = 8'hD4; 8'd77: b = 8'hB7; 8'd78: b = 8'h5A; 8'd79: b = 8'h92;
            8'd80: b = 8'h4E; 8'd81: b = 8'hBF; 8'd82: b = 8'hDA; 8'd83: b = 8'hBF;
            8'd84: b = 8'hFA; 8'd85: b = 8'h56; 8'd86: b = 8'hD4; 8'd87: b = 8'hD7;
            8'd88: b = 8'h48; 8'd89: b = 8'h56; 8'd90: b = 8'hF6; 8'd91: b = 8'hD7;
            8'd92: b = 8'hEA; 8'd93: b = 8'h71; 8'd94: b = 8'h1C; 8'd95: b = 8'hE9;
            8'd96: b = 8'h24; 8'd97: b = 8'hB6; 8'd98: b = 8'hD6; 8'd99: b = 8'hB6;
            8'd100: b = 8'hA4; 8'd101: b = 8'hB7; 8'd102: b = 8'hFA; 8'd103: b = 8'hB5;
            8'd104: b = 8'h5A; 8'd105: b = 8'hB5; 8'd106: b = 8'h24; 8'd107: b = 8'hE5;
            8'd108: b = 8'h4E; 8'd109: b = 8'hF2; 8'd110: b = 8'h4E; 8'd111: b = 8'h88;
            8'd112: b = 8'h80; 8'd113: b = 8'hE4; 8'd114: b = 8'h9E; 8'd115: b = 8'h54;
            8'd116: b = 8'hE0; 8'd117: b = 8'h90; 8'd118: b = 8'hCE; 8'd119: b = 8'hF0;
            8'd120: b = 8'h9A; 8'd121: b = 8'hDC; 8'd122: b = 8'h72; 8'd123: b = 8'h30;
            8'd124: b = 8'h2E; 8'd125: b = 8'hD6; 8'd126: b = 8'h77; 8'd127: b = 8'h30;
            8'd128: b = 8'h2B; 8'd129: b = 8'hA4; 8'd130: b = 8'h77; 8'd131: b = 8'h94;
            8'd132: b = 8'h9A; 8'd133: b = 8'hDA; 8'd134: b = 8'hB8; 8'd135: b = 8'h20;
            8'd136: b = 8'h9A; 8'd137: b = 8'h80; 8'd138: b = 8'h97; 8'd139: b = 8'h6A;
            8'd140: b = 8'hC9; 8'd141: b = 8'h2E; 8'd142: b = 8'hFF; 8'd143: b = 8'hD0;
            8'd144: b = 8'hD6; 8'd145: b = 8'hD0; 8'd146: b = 8'h56; 8'd147: b = 8'hA0;
            8'd148: b = 8'hD6; 8'd149: b = 8'hE8; 8'd150: b = 8'h76; 8'd151: b = 8'hB2;
            8'd152: b = 8'h72; 8'd153: b = 8'h40; 8'd154: b = 8'h79; 8'd155: b = 8'hE0;
            8'd156: b = 8'h5D; 8'd157: b = 8'h26; 8'd158: b = 8'hB6; 8'd159: b = 8'hB0;
            8'd160: b = 8'hB7; 8'd161: b = 8'hA0; 8'd162: b = 8'hBF; 8'd163: b = 8'hF0;
            8'd164: b = 8'hA9; 8'd165: b = 8'h50; 8'd166: b = 8'hB5; 8'd167: b = 8'h94;
            8'd168: b = 8'hEF; 8'd169: b = 8'h70; 8'd170: b = 8'h6A; 8'd171: b = 8'h26;
            8'd172: b = 8'hD8; 8'd173: b = 8'hC8; 8'd174: b = 8'hAC; 8'd175: b = 8'h78;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic t_glyph mk(input int o, input int w, input int h, input int a,
                                  input int y);
        t_glyph g;
        g.off = o[7:0];
        g.w   = w[1:0];
        g.h   = h[2:0];
        g.adv = a[2:0];
        g.yo  = y[3:0];
        return g;
    endfunction

    // glyph table indexed by code - FIRST_CODE
    function automatic t_glyph glyph_of(input logic [6:0] i);
        t_glyph g;
        case (i)
            7'd0: g = mk(0,1,1,2,-5);    7'd1: g = mk(1,1,5,2,-5);
            7'd2: g = mk(2,3,2,4,-5);    7'd3: g = mk(3,3,5,4,-5);
            7'd4: g = mk(5,3,5,4,-5);    7'd5: g = mk(7,3,5,4,-5);
            7'd6: g = mk(9,3,5,4,-5);    7'd7: g = mk(11,1,2,2,-5);
            7'd8: g = mk(12,2,5,3,-5);   7'd9: g = mk(14,2,5,3,-5);
            7'd10: g = mk(16,3,3,4,-5);  7'd11: g = mk(18,3,3,4,-4);
            7'd12: g = mk(20,2,2,3,-2);  7'd13: g = mk(21,3,1,4,-3);
            7'd14: g = mk(22,1,1,2,-1);  7'd15: g = mk(23,3,5,4,-5);
            7'd16: g = mk(25,3,5,4,-5);  7'd17: g = mk(27,2,5,3,-5);
            7'd18: g = mk(29,3,5,4,-5);  7'd19: g = mk(31,3,5,4,-5);
            7'd20: g = mk(33,3,5,4,-5);  7'd21: g = mk(35,3,5,4,-5);
            7'd22: g = mk(37,3,5,4,-5);  7'd23: g = mk(39,3,5,4,-5);
            7'd24: g = mk(41,3,5,4,-5);  7'd25: g = mk(43,3,5,4,-5);
            7'd26: g = mk(45,1,3,2,-4);  7'd27: g = mk(46,2,4,3,-4);
            7'd28: g = mk(47,3,5,4,-5);  7'd29: g = mk(49,3,3,4,-4);
            7'd30: g = mk(51,3,5,4,-5);  7'd31: g = mk(53,3,5,4,-5);
            7'd32: g = mk(55,3,5,4,-5);  7'd33: g = mk(57,3,5,4,-5);
            7'd34: g = mk(59,3,5,4,-5);  7'd35: g = mk(61,3,5,4,-5);
            7'd36: g = mk(63,3,5,4,-5);  7'd37: g = mk(65,3,5,4,-5);
            7'd38: g = mk(67,3,5,4,-5);  7'd39: g = mk(69,3,5,4,-5);
            7'd40: g = mk(71,3,5,4,-5);  7'd41: g = mk(73,3,5,4,-5);
            7'd42: g = mk(75,3,5,4,-5);  7'd43: g = mk(77,3,5,4,-5);
            7'd44: g = mk(79,3,5,4,-5);  7'd45: g = mk(81,3,5,4,-5);
            7'd46: g = mk(83,3,5,4,-5);  7'd47: g = mk(85,3,5,4,-5);
            7'd48: g = mk(87,3,5,4,-5);  7'd49: g = mk(89,3,5,4,-5);
            7'd50: g = mk(91,3,5,4,-5);  7'd51: g = mk(93,3,5,4,-5);
            7'd52: g = mk(95,3,5,4,-5);  7'd53: g = mk(97,3,5,4,-5);
            7'd54: g = mk(99,3,5,4,-5);  7'd55: g = mk(101,3,5,4,-5);
            7'd56: g = mk(103,3,5,4,-5); 7'd57: g = mk(105,3,5,4,-5);
            7'd58: g = mk(107,3,5,4,-5); 7'd59: g = mk(109,3,5,4,-5);
            7'd60: g = mk(111,3,3,4,-4); 7'd61: g = mk(113,3,5,4,-5);
            7'd62: g = mk(115,3,2,4,-5); 7'd63: g = mk(116,3,1,4,-1);
            7'd64: g = mk(117,2,2,3,-5); 7'd65: g = mk(118,3,4,4,-4);
            7'd66: g = mk(120,3,5,4,-5); 7'd67: g = mk(122,3,4,4,-4);
            7'd68: g = mk(124,3,5,4,-5); 7'd69: g = mk(126,3,4,4,-4);
            7'd70: g = mk(128,3,5,4,-5); 7'd71: g = mk(130,3,5,4,-4);
            7'd72: g = mk(132,3,5,4,-5); 7'd73: g = mk(134,1,5,2,-5);
            7'd74: g = mk(135,3,6,4,-5); 7'd75: g = mk(138,3,5,4,-5);
            7'd76: g = mk(140,3,5,4,-5); 7'd77: g = mk(142,3,4,4,-4);
            7'd78: g = mk(144,3,4,4,-4); 7'd79: g = mk(146,3,4,4,-4);
            7'd80: g = mk(148,3,5,4,-4); 7'd81: g = mk(150,3,5,4,-4);
            7'd82: g = mk(152,3,4,4,-4); 7'd83: g = mk(154,3,4,4,-4);
            7'd84: g = mk(156,3,5,4,-5); 7'd85: g = mk(158,3,4,4,-4);
            7'd86: g = mk(160,3,4,4,-4); 7'd87: g = mk(162,3,4,4,-4);
            7'd88: g = mk(164,3,4,4,-4); 7'd89: g = mk(166,3,5,4,-4);
            7'd90: g = mk(168,3,4,4,-4); 7'd91: g = mk(170,3,5,4,-5);
            7'd92: g = mk(172,1,5,2,-5); 7'd93: g = mk(173,3,5,4,-5);
            7'd94: g = mk(175,3,2,4,-5);
            default: g = mk(0,1,1,2,-5);
        endcase
        return g;
    endfunction

endpackage

@@ hdl/bgr_if.sv @@
// ----------------------------------------------------------------------------
// bgr_in_if / bgr_out_if: valid/ready channels of the character generator
// Source and sink modports carry valid, ready and the payload fields.
// ----------------------------------------------------------------------------
interface bgr_in_if #(parameter int COORD_BITS = 10);
    logic                         valid;
    logic                         ready;
    logic [7:0]                   char_code;
    logic                         new_text;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] base_y;
    logic                         color;
    modport source (output valid, char_code, new_text, start_x, base_y, color,
                    input ready);
    modport sink   (input valid, char_code, new_text, start_x, base_y, color,
                    output ready);
endinterface

interface bgr_out_if #(parameter int COORD_BITS = 10);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         pixel_color;
    logic                         pixel_valid;
    logic [2:0]                   advance;
    logic                         last;
    modport source (output valid, pixel_x, pixel_y, pixel_color, pixel_valid, advance,
                    last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, pixel_valid, advance,
                    last, output ready);
endinterface

@@ hdl/bgr_seq.sv @@
// ----------------------------------------------------------------------------
// bgr_seq: glyph bit sequencer
// Loads glyph bytes into a shift register and walks the cells one per cycle while i_step is high,
// keeping row and column counters; reports set cells and the closing step.
// ----------------------------------------------------------------------------
module bgr_seq
    import bgr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_code,
    input  logic       i_step,
    output logic       o_busy,
    output t_seq_ev    o_ev,
    output logic [1:0] o_col,
    output logic [2:0] o_row,
    output logic signed [3:0] o_yo
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CELL = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    t_glyph     r_g;
    logic [7:0] r_sh;       // bitmap byte, MSB is the current cell
    logic [2:0] r_bit;      // bits left in r_sh minus one
    logic [7:0] r_addr;     // next ROM byte
    logic [1:0] r_col;
    logic [2:0] r_row;
    logic [4:0] r_cnt;      // pixels emitted so far
    logic [6:0] gi;
    t_glyph     g_new;
    logic       last_cell, set_bit;

    // unprintable codes map to space
    always_comb begin
        if (i_code < FIRST_CODE || i_code > LAST_CODE) begin
            gi = 7'd0;
        end else begin
            gi = 7'(i_code - FIRST_CODE);
        end
        g_new = glyph_of(gi);
    end

    assign set_bit   = r_sh[7] && (r_cnt < 5'(MAX_PIX));
    assign last_cell = (r_col == r_g.w - 2'd1) && (r_row == r_g.h - 3'd1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_CELL;
            S_CELL: if (i_step && last_cell) n_state = S_DONE;
            S_DONE: if (i_step) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // cell walk: one glyph bit per step
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_g    <= g_new;
            r_sh   <= rom_byte(g_new.off);
            r_addr <= g_new.off + 8'd1;
            r_bit  <= 3'd7;
            r_col  <= 2'd0;
            r_row  <= 3'd0;
            r_cnt  <= 5'd0;
        end else if (r_state == S_CELL && i_step) begin
            if (set_bit) r_cnt <= r_cnt + 5'd1;
            if (r_bit == 3'd0) begin
                r_sh   <= rom_byte(r_addr);
                r_addr <= r_addr + 8'd1;
                r_bit  <= 3'd7;
            end else begin
                r_sh  <= {r_sh[6:0], 1'b0};
                r_bit <= r_bit - 3'd1;
            end
            if (r_col == r_g.w - 2'd1) begin
                r_col <= 2'd0;
                r_row <= r_row + 3'd1;
            end else begin
                r_col <= r_col + 2'd1;
            end
        end
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_ev.pix   = (r_state == S_CELL) && set_bit;
    assign o_ev.close = (r_state == S_DONE);
    assign o_ev.adv   = r_g.adv;
    assign o_col      = r_col;
    assign o_row      = r_row;
    assign o_yo       = r_g.yo;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cnt <= 5'(MAX_PIX))) else $error("pixel count overflow");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> r_state == S_CELL)
        else $error("start not taken");
    a_close_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_step) |=> r_state == S_IDLE)
        else $error("closing step repeated");
endmodule

@@ hdl/bitmap_glyph_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// bitmap_glyph_rasterizer_unit: proportional bitmap font character generator
//
// Input channel (bgr_in_if sink): one transaction per character with code,
// new_text/start_x for the pen, base_y and color. Output channel
// (bgr_out_if source): one transaction per set glyph cell with saturated
// pixel coordinates, then a closing transaction with advance and last = 1.
// The glyph is walked one cell per cycle, unless the receiver stalls, from
// a bit shift register fed by the font ROM; all w*h cells are walked. A set
// cell enters the output register as the walk steps past it. After the
// input transaction the sequencer walks the cells, then enters its closing
// state, which loads the closing transaction. One character at a time; the
// next is accepted once the closing transaction has entered the output
// register.
// The output register holds a transaction while the receiver stalls and
// the cell walk waits with it. Reset clears the pen x to 0 and empties
// the output register.
// ----------------------------------------------------------------------------
module bitmap_glyph_rasterizer_unit
    import bgr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic  i_clk,
    input  logic  i_rst_n,
    bgr_in_if.sink    i_in,
    bgr_out_if.source o_out
);
    localparam int W = COORD_BITS + 2;
    localparam logic signed [W-1:0] HI = W'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [W-1:0] LO = -HI - W'(1);

    logic signed [COORD_BITS-1:0] r_pen, r_by;
    logic                         r_color;
    logic                         r_ov;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic                         r_pc, r_pv, r_last;
    logic [2:0]                   r_adv;

    logic       busy, step, start, can_load;
    t_seq_ev    ev;
    logic [1:0] col;
    logic [2:0] row;
    logic signed [3:0] yo;
    logic signed [W-1:0] sx, sy, sp;

    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [W-1:0] v);
        if (v > HI) return HI[COORD_BITS-1:0];
        if (v < LO) return LO[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

    assign can_load = !r_ov || o_out.ready;
    assign start    = i_in.valid && i_in.ready;
    assign step     = can_load && (ev.pix || ev.close || busy);
    assign i_in.ready = !busy;

    bgr_seq u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_code (i_in.char_code),
        .i_step (step),
        .o_busy (busy),
        .o_ev   (ev),
        .o_col  (col),
        .o_row  (row),
        .o_yo   (yo)
    );

    // coordinate sums
    assign sx = W'(r_pen) + W'(col);
    assign sy = W'(r_by) + W'(yo) + W'(row);
    assign sp = W'(r_pen) + W'(ev.adv);

    // character registers and pen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen <= '0;
        end else if (start) begin
            if (i_in.new_text) r_pen <= i_in.start_x;
        end else if (ev.close && can_load) begin
            r_pen <= sat(sp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_by    <= i_in.base_y;
            r_color <= i_in.color;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (can_load) begin
            r_ov <= ev.pix || ev.close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load) begin
            r_pv   <= ev.pix;
            r_last <= ev.close;
            r_adv  <= ev.close ? ev.adv : 3'd0;
            r_px   <= ev.pix ? sat(sx) : '0;
            r_py   <= ev.pix ? sat(sy) : '0;
            r_pc   <= ev.pix ? r_color : 1'b0;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.pixel_x     = r_px;
    assign o_out.pixel_y     = r_py;
    assign o_out.pixel_color = r_pc;
    assign o_out.pixel_valid = r_pv;
    assign o_out.advance     = r_adv;
    assign o_out.last        = r_last;

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_pv != r_last)) else $error("transaction kind mismatch");
    a_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_last) |-> (r_adv != 3'd0)) else $error("zero advance");
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !i_in.ready) else $error("input taken while busy");
endmodule

@@ sim/bitmap_glyph_rasterizer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// bitmap_glyph_rasterizer_unit_tb: self-checking bench for the character generator
// Drives characters through the input channel with random gaps, predicts the
// pixel and closing transactions of each glyph, and compares every output
// transaction field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module bitmap_glyph_rasterizer_unit_tb;
    import bgr_pkg::*;

    localparam int CB = 10;
    localparam int WATCHDOG = 4000;
    localparam logic signed [CB-1:0] C_MAX = 511;
    localparam logic signed [CB-1:0] C_MIN = -512;

    typedef struct packed {
        logic [7:0]           code;
        logic                 load;
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] by;
        logic                 col;
    } t_char;

    typedef struct packed {
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        logic                 pc;
        logic                 pv;
        logic [2:0]           adv;
        logic                 lst;
    } t_pix;

    // directed row: character plus optional typed-in closing advance
    typedef struct {
        t_char ch;
        bit    has_adv;
        int    adv;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bgr_in_if  #(.COORD_BITS(CB)) in_ch();
    bgr_out_if #(.COORD_BITS(CB)) out_ch();

    bitmap_glyph_rasterizer_unit #(.COORD_BITS(CB)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // 20-unit clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_pix  pixel_queue[$];
    logic signed [CB-1:0] pen_x_model;
    int    fail_cnt = 0;
    int    idle_cycles = 0;
    int    want_adv[$];

    // glyph bitmap bit at a bit position (own table copy)
    function automatic bit font_bit(int pos);
        byte unsigned rom [0:175] = '{
            8'h00,8'hE8,8'hB4,8'hBE,8'hFA,8'h79,8'hE4,8'h85,8'h42,8'hDB,8'hD6,8'hC0,
            8'h6A,8'h40,8'h95,8'h80,8'hAA,8'h80,8'h5D,8'h00,8'h60,8'hE0,8'h80,8'h25,
            8'h48,8'h76,8'hDC,8'h75,8'h40,8'hC5,8'h4E,8'hC5,8'h1C,8'hB7,8'h92,8'hF3,
            8'h1C,8'h73,8'hDE,8'hE5,8'h48,8'hF7,8'hDE,8'hF7,8'h9C,8'hA0,8'h46,8'h2A,
            8'h22,8'hE3,8'h80,8'h88,8'hA8,8'hE5,8'h04,8'h57,8'hC6,8'h57,8'hDA,8'hD7,
            8'h5C,8'h72,8'h46,8'hD6,8'hDC,8'hF3,8'hCE,8'hF3,8'hC8,8'h73,8'hD6,8'hB7,
            8'hDA,8'hE9,8'h2E,8'h24,8'hD4,8'hB7,8'h5A,8'h92,8'h4E,8'hBF,8'hDA,8'hBF,
            8'hFA,8'h56,8'hD4,8'hD7,8'h48,8'h56,8'hF6,8'hD7,8'hEA,8'h71,8'h1C,8'hE9,
            8'h24,8'hB6,8'hD6,8'hB6,8'hA4,8'hB7,8'hFA,8'hB5,8'h5A,8'hB5,8'h24,8'hE5,
            8'h4E,8'hF2,8'h4E,8'h88,8'h80,8'hE4,8'h9E,8'h54,8'hE0,8'h90,8'hCE,8'hF0,
            8'h9A,8'hDC,8'h72,8'h30,8'h2E,8'hD6,8'h77,8'h30,8'h2B,8'hA4,8'h77,8'h94,
            8'h9A,8'hDA,8'hB8,8'h20,8'h9A,8'h80,8'h97,8'h6A,8'hC9,8'h2E,8'hFF,8'hD0,
            8'hD6,8'hD0,8'h56,8'hA0,8'hD6,8'hE8,8'h76,8'hB2,8'h72,8'h40,8'h79,8'hE0,
            8'h5D,8'h26,8'hB6,8'hB0,8'hB7,8'hA0,8'hBF,8'hF0,8'hA9,8'h50,8'hB5,8'h94,
            8'hEF,8'h70,8'h6A,8'h26,8'hD8,8'hC8,8'hAC,8'h78};
        if ((pos >> 3) >= 176) return 1'b0;
        return rom[pos >> 3][7 - (pos & 7)];
    endfunction

    function automatic logic signed [CB-1:0] clamp_coord(int v);
        if (v > C_MAX) return C_MAX;
        if (v < C_MIN) return C_MIN;
        return v[CB-1:0];
    endfunction

    // predict the transactions of one character and advance the pen
    task automatic predict_glyph(input t_char ch);
        int gofs [0:94] = '{0,1,2,3,5,7,9,11,12,14,16,18,20,21,22,23,25,27,29,31,
            33,35,37,39,41,43,45,46,47,49,51,53,55,57,59,61,63,65,67,69,71,73,75,77,
            79,81,83,85,87,89,91,93,95,97,99,101,103,105,107,109,111,113,115,116,117,
            118,120,122,124,126,128,130,132,134,135,138,140,142,144,146,148,150,152,
            154,156,158,160,162,164,166,168,170,172,173,175};
        int gw [0:94] = '{1,1,3,3,3,3,3,1,2,2,3,3,2,3,1,3,3,2,3,3,3,3,3,3,3,3,1,2,
            3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,
            2,3,3,3,3,3,3,3,3,1,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,3,1,3,3};
        int gh [0:94] = '{1,5,2,5,5,5,5,2,5,5,3,3,2,1,1,5,5,5,5,5,5,5,5,5,5,5,3,4,
            5,3,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,3,5,2,1,
            2,4,5,4,5,4,5,5,5,5,6,5,5,4,4,4,5,5,4,4,5,4,4,4,4,5,4,5,5,5,2};
        int gyo [0:94] = '{-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-4,-2,-3,-1,-5,-5,-5,
            -5,-5,-5,-5,-5,-5,-5,-5,-4,-4,-5,-4,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,
            -5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-5,-4,-5,-5,-1,-5,-4,
            -5,-4,-5,-4,-5,-4,-5,-5,-5,-5,-5,-4,-4,-4,-4,-4,-4,-4,-5,-4,-4,-4,-4,-4,
            -4,-5,-5,-5,-5};
        int idx, pos, n, adv;
        t_pix p;
        idx = (ch.code < FIRST_CODE || ch.code > LAST_CODE) ? 0 : ch.code - FIRST_CODE;
        adv = (gw[idx] == 1) ? 2 : (gw[idx] == 2) ? 3 : 4;
        if (ch.load) pen_x_model = ch.sx;
        pos = gofs[idx] * 8;
        n = 0;
        for (int r = 0; r < gh[idx]; r++) begin
            for (int c = 0; c < gw[idx]; c++) begin
                if (font_bit(pos) && n < MAX_PIX) begin
                    p.px  = clamp_coord(int'(pen_x_model) + c);
                    p.py  = clamp_coord(int'(ch.by) + gyo[idx] + r);
                    p.pc  = ch.col;
                    p.pv  = 1'b1;
                    p.adv = 3'd0;
                    p.lst = 1'b0;
                    pixel_queue.push_back(p);
                    n++;
                end
                pos++;
            end
        end
        p = '0;
        p.adv = adv[2:0];
        p.lst = 1'b1;
        pixel_queue.push_back(p);
        pen_x_model = clamp_coord(int'(pen_x_model) + adv);
    endtask

    // send one character after a random gap; valid stays up after the
    // transaction until the next gap or the end of stimulus
    task automatic send_char(input t_char ch);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.char_code  <= ch.code;
        in_ch.new_text   <= ch.load;
        in_ch.start_x    <= ch.sx;
        in_ch.base_y     <= ch.by;
        in_ch.color      <= ch.col;
        do @(posedge i_clk); while (!(in_ch.ready === 1'b1));
        predict_glyph(ch);
    endtask

    function automatic t_char rand_char();
        t_char ch;
        int k;
        k = $urandom_range(0, 9);
        ch.code = (k == 0) ? 8'($urandom) : 8'($urandom_range(32, 126));
        ch.load = ($urandom_range(0, 4) == 0);
        k = $urandom_range(0, 9);
        ch.sx = (k == 0) ? C_MAX - 10'sd2 : (k == 1) ? C_MIN : CB'($urandom);
        k = $urandom_range(0, 9);
        ch.by = (k == 0) ? C_MAX : (k == 1) ? C_MIN + 10'sd1 : CB'($urandom);
        ch.col = 1'($urandom_range(0, 1));
        return ch;
    endfunction

    // output side: random stall per transaction, check against oldest prediction
    initial begin
        int hold;
        t_pix got, exp_p;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = $urandom_range(0, 6);
            if (hold != 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk);
            while (!(out_ch.valid === 1'b1 && i_rst_n === 1'b1));
            got = {out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_color,
                   out_ch.pixel_valid, out_ch.advance, out_ch.last};
            if (pixel_queue.size() == 0) begin
                $error("unexpected transaction x=%0d y=%0d", got.px, got.py);
                fail_cnt++;
            end else begin
                exp_p = pixel_queue.pop_front();
                if (got.px !== exp_p.px) begin
                    $error("pixel_x exp %0d got %0d", exp_p.px, got.px); fail_cnt++;
                end
                if (got.py !== exp_p.py) begin
                    $error("pixel_y exp %0d got %0d", exp_p.py, got.py); fail_cnt++;
                end
                if (got.pc !== exp_p.pc) begin
                    $error("pixel_color exp %0d got %0d", exp_p.pc, got.pc);
                    fail_cnt++;
                end
                if (got.pv !== exp_p.pv) begin
                    $error("pixel_valid exp %0d got %0d", exp_p.pv, got.pv);
                    fail_cnt++;
                end
                if (got.adv !== exp_p.adv) begin
                    $error("advance exp %0d got %0d", exp_p.adv, got.adv); fail_cnt++;
                end
                if (got.lst !== exp_p.lst) begin
                    $error("last exp %0d got %0d", exp_p.lst, got.lst); fail_cnt++;
                end
                if (exp_p.lst && want_adv.size() > 0 && want_adv[0] >= 0) begin
                    if (got.adv !== want_adv[0]) begin
                        $error("advance exp %0d got %0d", want_adv[0], got.adv);
                        fail_cnt++;
                    end
                end
                if (exp_p.lst && want_adv.size() > 0) void'(want_adv.pop_front());
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_row dir_rows[$];
        t_row row;
        in_ch.valid      <= 1'b0;
        in_ch.char_code  <= 8'h00;
        in_ch.new_text   <= 1'b0;
        in_ch.start_x    <= '0;
        in_ch.base_y     <= '0;
        in_ch.color      <= 1'b0;
        pen_x_model = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: space, unprintable codes, extremes, pen saturation
        dir_rows = '{
            '{'{8'h20, 1'b0, 10'sd0, 10'sd0, 1'b1}, 1, 2},
            '{'{8'h00, 1'b0, 10'sd0, 10'sd5, 1'b1}, 1, 2},
            '{'{8'h1F, 1'b1, 10'sd7, 10'sd5, 1'b0}, 1, 2},
            '{'{8'h7F, 1'b0, 10'sd0, 10'sd5, 1'b1}, 1, 2},
            '{'{8'hFF, 1'b0, 10'sd0, 10'sd5, 1'b1}, 1, 2},
            '{'{8'h21, 1'b1, 10'sd0, 10'sd10, 1'b1}, 1, 2},
            '{'{8'h7E, 1'b0, 10'sd0, 10'sd10, 1'b0}, 1, 4},
            '{'{8'h40, 1'b1, 10'sd510, 10'sd511, 1'b1}, 1, 4},
            '{'{8'h57, 1'b0, 10'sd0, 10'sd511, 1'b1}, 1, 4},
            '{'{8'h4D, 1'b1, -10'sd512, -10'sd512, 1'b1}, 1, 4},
            '{'{8'h2A, 1'b1, -10'sd3, 10'sd2, 1'b0}, 0, 0},
            '{'{8'h67, 1'b0, 10'sd0, -10'sd1, 1'b1}, 0, 0},
            '{'{8'h6A, 1'b0, 10'sd0, 10'sd0, 1'b1}, 0, 0},
            '{'{8'h7C, 1'b1, 10'sd509, 10'sd508, 1'b1}, 0, 0},
            '{'{8'h2E, 1'b1, 10'sd100, 10'sd100, 1'b0}, 0, 0},
            '{'{8'h5F, 1'b0, 10'sd0, -10'sd100, 1'b1}, 0, 0},
            '{'{8'h80, 1'b1, -10'sd1, 10'sd0, 1'b1}, 1, 2}
        };
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            want_adv.push_back(row.has_adv ? row.adv : -1);
            send_char(row.ch);
        end

        for (int k = 0; k < 350; k++) begin
            // hold off until the block has drained everything
            if (k == 150) begin
                in_ch.valid <= 1'b0;
                wait (pixel_queue.size() == 0);
            end
            want_adv.push_back(-1);
            send_char(rand_char());
        end
        in_ch.valid <= 1'b0;

        wait (pixel_queue.size() == 0);
        repeat (30) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/bgr_pkg.sv
hdl/bgr_if.sv
hdl/bgr_seq.sv
hdl/bitmap_glyph_rasterizer_unit.sv
sim/bitmap_glyph_rasterizer_unit_tb.sv
